// ===== hw/rtl/knxrx_pkg.sv =====
// knxrx_pkg: types and constants shared by the twisted-pair frame receiver
// no dependencies; compile first

package knxrx_pkg;

    localparam int CfgIdxW = 8;

    // frame layout
    localparam logic [4:0] HDR_LEN      = 5'd6;
    localparam logic [4:0] FRAME_EXTRA  = 5'd7;    // header plus checksum
    localparam logic [4:0] POS_MAX      = 5'd31;
    localparam logic [7:0] XOR_GOOD     = 8'hFF;

    // header byte positions
    localparam logic [4:0] POS_CONTROL  = 5'd0;
    localparam logic [4:0] POS_SRC_HI   = 5'd1;
    localparam logic [4:0] POS_SRC_LO   = 5'd2;
    localparam logic [4:0] POS_DST_HI   = 5'd3;
    localparam logic [4:0] POS_DST_LO   = 5'd4;
    localparam logic [4:0] POS_ADDR_INF = 5'd5;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_BAD_SUM   = 2'd2;

    // record kinds
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_DATA    = 1'b1;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_MIN_LEN    = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_GROUP_MASK = 8'd1;

    // register reset values
    localparam logic [4:0] MIN_LEN_RST    = 5'd9;
    localparam logic [7:0] GROUP_MASK_RST = 8'h80;

    typedef struct packed {
        logic [7:0]  control;
        logic [15:0] source;
        logic [15:0] dest;
        logic [7:0]  addr_info;
    } t_hdr;

    typedef struct packed {
        logic       start;
        logic [1:0] status;
    } t_job;

    typedef struct packed {
        logic busy;
        logic done;
    } t_emit_stat;

endpackage

// ===== hw/rtl/knxrx_if.sv =====
// knxrx channel interfaces: received bytes, output records, register writes
// depends on knxrx_pkg

interface knxrx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface knxrx_out_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [1:0]  status;
    logic [7:0]  control_byte;
    logic [15:0] source_address;
    logic [15:0] dest_address;
    logic        dest_is_group;
    logic [2:0]  route_hops;
    logic [4:0]  apdu_length;
    logic [7:0]  apdu_byte;
    logic        last;

    modport source (output valid, output record_kind, output status, output control_byte,
                    output source_address, output dest_address, output dest_is_group,
                    output route_hops, output apdu_length, output apdu_byte, output last,
                    input ready);
    modport sink   (input valid, input record_kind, input status, input control_byte,
                    input source_address, input dest_address, input dest_is_group,
                    input route_hops, input apdu_length, input apdu_byte, input last,
                    output ready);
endinterface

interface knxrx_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [knxrx_pkg::CfgIdxW-1:0] index;
    logic [7:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/knxrx_emit.sv =====
// knxrx_emit: walks the records of one closed buffer into the output register
// depends on knxrx_pkg and knxrx_if

module knxrx_emit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  knxrx_pkg::t_job       i_job,
    input  knxrx_pkg::t_hdr       i_hdr,
    input  logic [7:0]            i_group_mask,
    input  logic [7:0]            i_apdu_data,
    output logic [3:0]            o_apdu_idx,
    output knxrx_pkg::t_emit_stat o_stat,
    knxrx_out_if.source           o_rec
);

    logic        r_busy, n_busy;
    logic [4:0]  r_idx, n_idx;
    logic [1:0]  r_status, n_status;
    logic        r_out_valid, n_out_valid;

    logic        r_kind;
    logic [1:0]  r_st;
    logic [7:0]  r_ctl;
    logic [15:0] r_src;
    logic [15:0] r_dst;
    logic        r_grp;
    logic [2:0]  r_hop;
    logic [4:0]  r_alen;
    logic [7:0]  r_abyte;
    logic        r_last;

    logic        kind, grp, last_rec, load;
    logic [1:0]  st;
    logic [7:0]  ctl, abyte;
    logic [15:0] src, dst;
    logic [2:0]  hop;
    logic [4:0]  alen, apdu_n, idx_m1;

    assign apdu_n     = {1'b0, i_hdr.addr_info[3:0]} + 5'd1;
    assign idx_m1     = r_idx - 5'd1;
    assign o_apdu_idx = idx_m1[3:0];
    assign load       = r_busy && (!r_out_valid || o_rec.ready);

    always_comb begin
        kind     = knxrx_pkg::KIND_SUMMARY;
        st       = knxrx_pkg::ST_OK;
        ctl      = 8'd0;
        src      = 16'd0;
        dst      = 16'd0;
        grp      = 1'b0;
        hop      = 3'd0;
        alen     = 5'd0;
        abyte    = 8'd0;
        last_rec = 1'b0;
        if (r_idx == 5'd0) begin
            st = r_status;
            if (r_status == knxrx_pkg::ST_OK) begin
                ctl  = i_hdr.control;
                src  = i_hdr.source;
                dst  = i_hdr.dest;
                grp  = |(i_hdr.addr_info & i_group_mask);
                hop  = i_hdr.addr_info[6:4];
                alen = apdu_n;
            end else begin
                last_rec = 1'b1;
            end
        end else begin
            kind     = knxrx_pkg::KIND_DATA;
            abyte    = i_apdu_data;
            last_rec = (r_idx == apdu_n);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = load && last_rec;

    always_comb begin
        n_busy   = r_busy;
        n_idx    = r_idx;
        n_status = r_status;
        if (i_job.start) begin
            n_busy   = 1'b1;
            n_idx    = 5'd0;
            n_status = i_job.status;
        end else if (load && last_rec) begin
            n_busy = 1'b0;
        end else if (load) begin
            n_idx = r_idx + 5'd1;
        end
        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_rec.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 5'd0;
            r_status    <= knxrx_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= kind;
            r_st    <= st;
            r_ctl   <= ctl;
            r_src   <= src;
            r_dst   <= dst;
            r_grp   <= grp;
            r_hop   <= hop;
            r_alen  <= alen;
            r_abyte <= abyte;
            r_last  <= last_rec;
        end
    end

    assign o_rec.valid          = r_out_valid;
    assign o_rec.record_kind    = r_kind;
    assign o_rec.status         = r_st;
    assign o_rec.control_byte   = r_ctl;
    assign o_rec.source_address = r_src;
    assign o_rec.dest_address   = r_dst;
    assign o_rec.dest_is_group  = r_grp;
    assign o_rec.route_hops     = r_hop;
    assign o_rec.apdu_length    = r_alen;
    assign o_rec.apdu_byte      = r_abyte;
    assign o_rec.last           = r_last;

endmodule

// ===== hw/rtl/knx_tp_frame_receiver.sv =====
// knx_tp_frame_receiver: standard-frame receiver top level, byte intake and checks
// depends on knxrx_pkg, knxrx_if and knxrx_emit
//
//   channel  | dir | request carries                    | accepted when
//   i_rx     | in  | rx_byte, buffer_end                | valid && ready
//   o_rec    | out | one summary or apdu data record    | valid && ready
//   i_cfg    | in  | index, data (min length, grp mask)| valid && ready (ready tied high)
//
// a byte is taken when valid and ready are high; header capture, xor and length
// checks are settled in the cycle of the request that carries it
// a closed buffer yields one summary and, if ok, 1 to 16 data records, one per cycle
// through the output register unless o_rec stalls it; i_rx.ready is low while they
// drain, rising again in the cycle the last record is loaded
// synchronous active-low reset clears position, xor and header, presets registers

module knx_tp_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    knxrx_in_if.sink    i_rx,
    knxrx_out_if.source o_rec,
    knxrx_cfg_if.sink   i_cfg
);

    logic [4:0]  r_min_len;
    logic [7:0]  r_group_mask;

    logic [4:0]  r_pos, n_pos;
    logic [7:0]  r_xor, n_xor;
    knxrx_pkg::t_hdr r_hdr, n_hdr;
    logic [7:0]  r_apdu [16];

    logic        take, in_hdr, in_frame, apdu_wr;
    logic [7:0]  xor_new;
    logic [4:0]  apdu_n, frm_size, apdu_lim, length, wr_off;
    logic [1:0]  status;
    logic [3:0]  rd_idx;

    knxrx_pkg::t_job       job;
    knxrx_pkg::t_emit_stat em_stat;

    assign i_rx.ready  = !em_stat.busy || em_stat.done;
    assign i_cfg.ready = 1'b1;
    assign take        = i_rx.valid && i_rx.ready;

    always_comb begin
        n_hdr  = r_hdr;
        in_hdr = (r_pos < knxrx_pkg::HDR_LEN);
        if (in_hdr) begin
            case (r_pos)
                knxrx_pkg::POS_CONTROL: n_hdr.control       = i_rx.rx_byte;
                knxrx_pkg::POS_SRC_HI:  n_hdr.source[15:8]  = i_rx.rx_byte;
                knxrx_pkg::POS_SRC_LO:  n_hdr.source[7:0]   = i_rx.rx_byte;
                knxrx_pkg::POS_DST_HI:  n_hdr.dest[15:8]    = i_rx.rx_byte;
                knxrx_pkg::POS_DST_LO:  n_hdr.dest[7:0]     = i_rx.rx_byte;
                default:                n_hdr.addr_info     = i_rx.rx_byte;
            endcase
        end

        apdu_n    = {1'b0, n_hdr.addr_info[3:0]} + 5'd1;
        frm_size  = apdu_n + knxrx_pkg::FRAME_EXTRA;
        apdu_lim  = apdu_n + knxrx_pkg::HDR_LEN;
        in_frame  = in_hdr || (r_pos < frm_size);
        xor_new   = in_frame ? (r_xor ^ i_rx.rx_byte) : r_xor;
        apdu_wr   = take && !in_hdr && (r_pos < apdu_lim);
        wr_off    = r_pos - knxrx_pkg::HDR_LEN;
        length    = (r_pos == knxrx_pkg::POS_MAX) ? knxrx_pkg::POS_MAX : r_pos + 5'd1;

        if (length < r_min_len || length < knxrx_pkg::HDR_LEN || length < frm_size) begin
            status = knxrx_pkg::ST_SHORT;
        end else if (xor_new != knxrx_pkg::XOR_GOOD) begin
            status = knxrx_pkg::ST_BAD_SUM;
        end else begin
            status = knxrx_pkg::ST_OK;
        end

        n_pos = r_pos;
        n_xor = r_xor;
        if (take) begin
            n_pos = i_rx.buffer_end ? 5'd0 : length;
            n_xor = i_rx.buffer_end ? 8'd0 : xor_new;
        end

        job.start  = take && i_rx.buffer_end;
        job.status = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= 5'd0;
            r_xor        <= 8'd0;
            r_hdr        <= '0;
            r_min_len    <= knxrx_pkg::MIN_LEN_RST;
            r_group_mask <= knxrx_pkg::GROUP_MASK_RST;
        end else begin
            r_pos <= n_pos;
            r_xor <= n_xor;
            if (take) begin
                r_hdr <= n_hdr;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    knxrx_pkg::CFG_MIN_LEN:    r_min_len    <= i_cfg.data[4:0];
                    knxrx_pkg::CFG_GROUP_MASK: r_group_mask <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // apdu bytes are held still while a buffer's records drain, input is stalled then
    always_ff @(posedge i_clk) begin
        if (apdu_wr) begin
            r_apdu[wr_off[3:0]] <= i_rx.rx_byte;
        end
    end

    knxrx_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job),
        .i_hdr        (r_hdr),
        .i_group_mask (r_group_mask),
        .i_apdu_data  (r_apdu[rd_idx]),
        .o_apdu_idx   (rd_idx),
        .o_stat       (em_stat),
        .o_rec        (o_rec)
    );

endmodule

// ===== bench/knx_tp_frame_receiver_tb.sv =====
// testbench for knx_tp_frame_receiver: random and directed receive buffers,
// a behavioural frame decoder predicting summary and apdu records
// depends on knxrx_pkg, knxrx_if and the receiver rtl

module knx_tp_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 330;
    localparam int PHASE_ITEMS   = 30;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    // indexes with no register behind them
    localparam logic [knxrx_pkg::CfgIdxW-1:0] CFG_SPARE_REG = 8'd2;
    localparam logic [knxrx_pkg::CfgIdxW-1:0] CFG_TOP_REG   = 8'hFF;

    typedef enum int {BUF_GOOD, BUF_BAD_SUM, BUF_TRUNC, BUF_NOISE} buf_form_t;

    typedef struct packed {
        logic [7:0] data;
        logic       closes;
    } rx_item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [7:0]  control;
        logic [15:0] source;
        logic [15:0] dest;
        logic        is_group;
        logic [2:0]  hops;
        logic [4:0]  apdu_cnt;
        logic [7:0]  apdu;
        logic        last;
    } frame_rec_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          rx_valid  = 1'b0;
    logic [7:0]                    rx_data   = 8'h00;
    logic                          rx_end    = 1'b0;
    logic                          rec_ready = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [knxrx_pkg::CfgIdxW-1:0] cfg_index = '0;
    logic [7:0]                    cfg_data  = 8'h00;

    knxrx_in_if  rx_ch ();
    knxrx_out_if rec_ch ();
    knxrx_cfg_if cfg_ch ();

    assign rx_ch.valid      = rx_valid;
    assign rx_ch.rx_byte    = rx_data;
    assign rx_ch.buffer_end = rx_end;
    assign rec_ch.ready     = rec_ready;
    assign cfg_ch.valid     = cfg_valid;
    assign cfg_ch.index     = cfg_index;
    assign cfg_ch.data      = cfg_data;

    knx_tp_frame_receiver dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_ch),
        .o_rec   (rec_ch),
        .i_cfg   (cfg_ch)
    );

    // decoder state, mirrors the receiver
    logic [4:0]       rx_pos;
    logic [7:0]       rx_sum;
    knxrx_pkg::t_hdr  rx_hdr;
    logic [7:0]       apdu_buf [16];
    logic [4:0]       min_len;
    logic [7:0]       group_mask;

    rx_item_t    rx_backlog [$];
    frame_rec_t  frame_records_due [$];
    int          rx_queued   = 0;
    int          rx_accepted = 0;
    int          fail_count  = 0;
    int          recs_checked = 0;
    int          n_ok = 0, n_short = 0, n_bad_sum = 0;
    int          n_settings = 1;

    logic        rx_took  = 1'b0;
    logic        cfg_took = 1'b0;
    frame_rec_t  got, want;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic string rec_text(frame_rec_t r);
        return $sformatf({"kind %0d st %0d ctl %02h src %04h dst %04h grp %0d",
                          " hop %0d len %0d byte %02h last %0d"},
                         r.kind, r.status, r.control, r.source, r.dest, r.is_group,
                         r.hops, r.apdu_cnt, r.apdu, r.last);
    endfunction

    function automatic frame_rec_t failed_rec(logic [1:0] st);
        frame_rec_t r;
        r = '0;
        r.kind   = knxrx_pkg::KIND_SUMMARY;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    // one accepted byte through the frame decoder; records due are queued at buffer end
    task automatic decode_rx_byte(input logic [7:0] b, input logic closes);
        logic [4:0] pos;
        logic [4:0] n;
        logic [4:0] frm_size;
        logic [4:0] length;
        logic [4:0] slot;
        frame_rec_t r;
        pos = rx_pos;
        if (pos < knxrx_pkg::HDR_LEN) begin
            rx_sum ^= b;
            case (pos)
                knxrx_pkg::POS_CONTROL: rx_hdr.control      = b;
                knxrx_pkg::POS_SRC_HI:  rx_hdr.source[15:8] = b;
                knxrx_pkg::POS_SRC_LO:  rx_hdr.source[7:0]  = b;
                knxrx_pkg::POS_DST_HI:  rx_hdr.dest[15:8]   = b;
                knxrx_pkg::POS_DST_LO:  rx_hdr.dest[7:0]    = b;
                default:                rx_hdr.addr_info    = b;
            endcase
        end
        n = {1'b0, rx_hdr.addr_info[3:0]} + 5'd1;
        frm_size = knxrx_pkg::FRAME_EXTRA + n;
        if (pos >= knxrx_pkg::HDR_LEN && pos < frm_size) begin
            rx_sum ^= b;
            slot = pos - knxrx_pkg::HDR_LEN;
            if (slot < n) apdu_buf[slot[3:0]] = b;
        end
        length = (pos < knxrx_pkg::POS_MAX) ? pos + 5'd1 : knxrx_pkg::POS_MAX;
        rx_pos = length;
        if (!closes) return;

        rx_pos = '0;
        if (length < min_len || length < knxrx_pkg::HDR_LEN || length < frm_size) begin
            frame_records_due.push_back(failed_rec(knxrx_pkg::ST_SHORT));
            n_short++;
        end else if (rx_sum != knxrx_pkg::XOR_GOOD) begin
            frame_records_due.push_back(failed_rec(knxrx_pkg::ST_BAD_SUM));
            n_bad_sum++;
        end else begin
            r = '0;
            r.kind     = knxrx_pkg::KIND_SUMMARY;
            r.status   = knxrx_pkg::ST_OK;
            r.control  = rx_hdr.control;
            r.source   = rx_hdr.source;
            r.dest     = rx_hdr.dest;
            r.is_group = |(rx_hdr.addr_info & group_mask);
            r.hops     = rx_hdr.addr_info[6:4];
            r.apdu_cnt = n;
            frame_records_due.push_back(r);
            for (int i = 0; i < n; i++) begin
                r = '0;
                r.kind = knxrx_pkg::KIND_DATA;
                r.apdu = apdu_buf[i];
                r.last = (i == n - 1);
                frame_records_due.push_back(r);
            end
            n_ok++;
        end
        rx_sum = 8'h00;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic closes);
        rx_item_t it;
        it.data   = b;
        it.closes = closes;
        rx_backlog.push_back(it);
        rx_queued++;
    endtask

    // header, n apdu bytes and checksum, then extras; noise: random bytes, trunc: cut short
    task automatic queue_buffer(input int n, input buf_form_t form, input int extra);
        logic [7:0] frame_bytes [$];
        logic [7:0] b;
        logic [7:0] sum;
        int keep;
        sum = 8'h00;
        if (form == BUF_NOISE) begin
            for (int i = 0; i < extra; i++) begin
                b = 8'($urandom);
                frame_bytes.push_back(b);
            end
        end else begin
            for (int i = 0; i < 5; i++) begin
                b = 8'($urandom);
                frame_bytes.push_back(b);
            end
            b = 8'($urandom);
            b[3:0] = 4'(n - 1);
            frame_bytes.push_back(b);
            for (int i = 0; i < n; i++) begin
                b = 8'($urandom);
                frame_bytes.push_back(b);
            end
            foreach (frame_bytes[i]) sum ^= frame_bytes[i];
            b = ~sum;
            if (form == BUF_BAD_SUM) b ^= 8'($urandom_range(1, 255));
            frame_bytes.push_back(b);
            for (int i = 0; i < extra; i++) begin
                b = 8'($urandom);
                frame_bytes.push_back(b);
            end
        end
        keep = frame_bytes.size();
        if (form == BUF_TRUNC) keep = $urandom_range(1, keep - 1);
        for (int i = 0; i < keep; i++) queue_byte(frame_bytes[i], i == keep - 1);
    endtask

    task automatic write_reg(input logic [knxrx_pkg::CfgIdxW-1:0] idx,
                             input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_took);
        cfg_valid <= 1'b0;
    endtask

    // sender holds off until every request is taken and every record has come back
    task automatic drain();
        while (rx_accepted != rx_queued || frame_records_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // sender: bursts of random length, random gaps between them
    int burst_left = 8;
    int gap_left   = 0;
    rx_item_t next_item;

    always @(negedge clk) begin
        if (!rst_n) begin
            rx_valid <= 1'b0;
        end else if (!rx_valid || rx_took) begin
            if (gap_left > 0) begin
                gap_left--;
                rx_valid <= 1'b0;
            end else if (rx_backlog.size() > 0) begin
                next_item = rx_backlog.pop_front();
                rx_valid <= 1'b1;
                rx_data  <= next_item.data;
                rx_end   <= next_item.closes;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                rx_valid <= 1'b0;
            end
        end
    end

    // receiver stalls: always ready, random, or ready on periodic ticks; mode re-picked at random
    int ready_tick = 0;
    int ready_mode = 0;

    always @(negedge clk) begin
        ready_tick++;
        if (ready_tick % 50 == 0) ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0:       rec_ready <= 1'b1;
            1:       rec_ready <= ($urandom_range(0, 1) == 1);
            2:       rec_ready <= (ready_tick % 4 == 0);
            default: rec_ready <= (ready_tick % 8 == 7);
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            rx_took  <= 1'b0;
            cfg_took <= 1'b0;
        end else begin
            rx_took  <= rx_valid && rx_ch.ready;
            cfg_took <= cfg_valid && cfg_ch.ready;
            if (cfg_valid && cfg_ch.ready) begin
                case (cfg_index)
                    knxrx_pkg::CFG_MIN_LEN:    min_len    = cfg_data[4:0];
                    knxrx_pkg::CFG_GROUP_MASK: group_mask = cfg_data;
                    default: ;
                endcase
            end
            if (rx_valid && rx_ch.ready) begin
                decode_rx_byte(rx_data, rx_end);
                rx_accepted++;
            end
            if (rec_ch.valid && rec_ready) begin
                got.kind     = rec_ch.record_kind;
                got.status   = rec_ch.status;
                got.control  = rec_ch.control_byte;
                got.source   = rec_ch.source_address;
                got.dest     = rec_ch.dest_address;
                got.is_group = rec_ch.dest_is_group;
                got.hops     = rec_ch.route_hops;
                got.apdu_cnt = rec_ch.apdu_length;
                got.apdu     = rec_ch.apdu_byte;
                got.last     = rec_ch.last;
                recs_checked++;
                if (frame_records_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%t unexpected record: %s", $realtime, rec_text(got));
                end else begin
                    want = frame_records_due.pop_front();
                    if (got.kind !== want.kind || got.status !== want.status ||
                        got.control !== want.control || got.source !== want.source ||
                        got.dest !== want.dest || got.is_group !== want.is_group ||
                        got.hops !== want.hops || got.apdu_cnt !== want.apdu_cnt ||
                        got.apdu !== want.apdu || got.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%t record mismatch", $realtime);
                            $display("  expected %s", rec_text(want));
                            $display("  actual   %s", rec_text(got));
                        end
                    end
                end
            end
        end
    end

    initial begin
        int phase;
        int phase_start;
        int pick;
        int n;
        int extra;
        int frm_size;
        logic [7:0] value;

        rx_pos     = '0;
        rx_sum     = 8'h00;
        rx_hdr     = '0;
        min_len    = knxrx_pkg::MIN_LEN_RST;
        group_mask = knxrx_pkg::GROUP_MASK_RST;
        foreach (apdu_buf[i]) apdu_buf[i] = 8'h00;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed buffers at reset settings
        queue_byte(8'hFF, 1'b1);                      // single byte, under a header
        for (int i = 0; i < 7; i++) queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);                      // all-zero frame, one apdu byte
        queue_byte(8'h5A, 1'b1);                      // ignored byte past the frame
        for (int i = 0; i < 23; i++) queue_byte(8'hFF, i == 22);  // all ones, 16 apdu bytes
        drain();

        phase = 1;
        while (phase <= 5 || rx_queued < ITEM_TARGET) begin
            case (phase)
                1: begin
                    write_reg(knxrx_pkg::CFG_MIN_LEN, 8'd0);
                    write_reg(knxrx_pkg::CFG_GROUP_MASK, 8'h00);
                end
                2: begin
                    write_reg(knxrx_pkg::CFG_MIN_LEN, 8'hFF);     // upper bits dropped, bound 31
                    write_reg(knxrx_pkg::CFG_GROUP_MASK, 8'hFF);
                end
                3: begin
                    write_reg(knxrx_pkg::CFG_MIN_LEN, 8'd1);
                    write_reg(knxrx_pkg::CFG_GROUP_MASK, 8'h0F);
                end
                4: begin
                    write_reg(knxrx_pkg::CFG_MIN_LEN, 8'd23);
                    write_reg(knxrx_pkg::CFG_GROUP_MASK, 8'($urandom));
                end
                5: begin
                    write_reg(CFG_SPARE_REG, 8'($urandom));
                    write_reg(CFG_TOP_REG, 8'($urandom));
                    write_reg(knxrx_pkg::CFG_MIN_LEN, 8'd7);
                end
                default: begin
                    value = 8'($urandom);
                    value[4:0] = 5'($urandom_range(1, 23));
                    write_reg(knxrx_pkg::CFG_MIN_LEN, value);
                    write_reg(knxrx_pkg::CFG_GROUP_MASK, 8'($urandom));
                end
            endcase
            n_settings++;

            // frames right on and just under the minimum length, when it exceeds the frame size
            n = $urandom_range(1, 16);
            frm_size = 7 + n;
            queue_buffer(n, BUF_GOOD, (min_len > frm_size) ? min_len - frm_size : 0);
            if (min_len > frm_size) queue_buffer(n, BUF_GOOD, min_len - 1 - frm_size);

            phase_start = rx_queued;
            while (rx_queued - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0:       n = 16;
                    1, 2:    n = $urandom_range(1, 16);
                    default: n = $urandom_range(1, 4);
                endcase
                case ($urandom_range(0, 9))
                    0:       extra = $urandom_range(5, 30);
                    1, 2:    extra = $urandom_range(1, 3);
                    default: extra = 0;
                endcase
                if (pick < 65)      queue_buffer(n, BUF_GOOD, extra);
                else if (pick < 78) queue_buffer(n, BUF_BAD_SUM, extra);
                else if (pick < 90) queue_buffer(n, BUF_TRUNC, 0);
                else                queue_buffer(n, BUF_NOISE, $urandom_range(1, 35));
            end
            drain();
            phase++;
        end

        if (frame_records_due.size() != 0) begin
            fail_count += frame_records_due.size();
            $display("%0d expected records never arrived", frame_records_due.size());
        end
        $display("covered %0d bytes in %0d buffers over %0d register settings",
                 rx_accepted, n_ok + n_short + n_bad_sum, n_settings);
        $display("buffers ok %0d, too short %0d, bad checksum %0d; %0d records checked, %0d errors",
                 n_ok, n_short, n_bad_sum, recs_checked, fail_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("timeout: %0d of %0d bytes taken, %0d records outstanding",
                 rx_accepted, rx_queued, frame_records_due.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
